// ===== design/assert_macros.svh =====
// Assertion helpers for the timer controller.
// Both expect clk in scope; FIT_ASSERT also expects rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define FIT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Checked on every edge, reset included.
`define FIT_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/fit_pkg.sv =====
package fit_pkg;

  // Field and register widths.
  localparam int OP_W       = 2;
  localparam int TS_W       = 32;
  localparam int NV_W       = 48;
  localparam int LOOP_W     = 24;
  localparam int REAL_W     = 48;
  localparam int PER_W      = 24;
  localparam int WIN_W      = 12;
  localparam int CNT_W      = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int NUM_LANES  = 3;

  // Defaults of the top-level parameters.
  localparam int TIME_BITS_DEF     = 48;
  localparam int INTERVAL_BITS_DEF = 24;

  // Milliseconds to microseconds, and the width of the divider input.
  localparam int SCALE   = 1000;
  localparam int DIVD_W  = TS_W + $clog2(SCALE);
  localparam int DSTEP_W = $clog2(DIVD_W + 1);

  // Operation codes.
  localparam logic [OP_W-1:0] OP_TICK      = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD_TIME = 2'd1;
  localparam logic [OP_W-1:0] OP_LOAD_IVL  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_FRAME  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AVG_WINDOW = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_A   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_B   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_C   = 3'd4;

  // Configuration reset values.
  localparam logic [PER_W-1:0] MAX_FRAME_RST  = 24'd1000000;
  localparam logic [WIN_W-1:0] AVG_WINDOW_RST = 12'd10;
  localparam logic [PER_W-1:0] PERIOD_A_RST   = 24'd33333;
  localparam logic [PER_W-1:0] PERIOD_B_RST   = 24'd66667;
  localparam logic [PER_W-1:0] PERIOD_C_RST   = 24'd142857;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_CHECK,
    ST_DIV,
    ST_CLAMP,
    ST_ACC,
    ST_TOG_SUB,
    ST_TOG_FIX,
    ST_DONE
  } fit_state_t;

  typedef struct packed {
    logic capture;    // latch the incoming word
    logic tick_upd;   // delta, frame count, elapsed, last timestamp
    logic load_time;  // running time from new_value
    logic load_ivl;   // interval from new_value, saturated
    logic div_start;  // launch elapsed*1000/count
    logic div_take;   // write quotient, clear counters
    logic clamp;      // clamp interval to max_frame_us
    logic accum;      // running time and phase sums
    logic tog_sub;    // compare, flip, subtract period
    logic tog_fix;    // zero a sum still over its period
    logic out_load;   // copy state into the result register
  } fit_cmd_t;

  typedef struct packed {
    logic over_window;
    logic div_done;
  } fit_status_t;

endpackage

// ===== design/fit_div.sv =====
module fit_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [fit_pkg::DIVD_W-1:0] dividend,
  input  logic [fit_pkg::CNT_W-1:0]  divisor,
  output logic                       done,
  output logic [fit_pkg::DIVD_W-1:0] quotient
);

  localparam int DIVD_W  = fit_pkg::DIVD_W;
  localparam int DIVS_W  = fit_pkg::CNT_W;
  localparam int DSTEP_W = fit_pkg::DSTEP_W;

  logic [DIVS_W-1:0]  rem_r;
  logic [DIVD_W-1:0]  quo_r;
  logic [DIVS_W-1:0]  dvs_r;
  logic [DSTEP_W-1:0] step_r;
  logic               busy_r;
  logic               done_r;
  logic [DIVS_W:0]    rem_sh;
  logic [DIVS_W:0]    diff;
  logic               ge;

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  assign rem_sh = {rem_r, quo_r[DIVD_W-1]};
  assign ge     = rem_sh >= {1'b0, dvs_r};
  assign diff   = rem_sh - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= DSTEP_W'(DIVD_W);
      end else if (busy_r) begin
        step_r <= step_r - DSTEP_W'(1);
        if (step_r == DSTEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DIVS_W-1:0] : rem_sh[DIVS_W-1:0];
      quo_r <= {quo_r[DIVD_W-2:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== design/fit_dpath.sv =====
module fit_dpath #(
  parameter int TIME_BITS     = fit_pkg::TIME_BITS_DEF,
  parameter int INTERVAL_BITS = fit_pkg::INTERVAL_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  fit_pkg::fit_cmd_t              cmd,
  output fit_pkg::fit_status_t           status,
  input  logic [fit_pkg::TS_W-1:0]       in_timestamp_ms,
  input  logic [fit_pkg::NV_W-1:0]       in_new_value,
  input  logic                           cfg_wr_en,
  input  logic [fit_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fit_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output logic [fit_pkg::LOOP_W-1:0]     out_loop_time_us,
  output logic [fit_pkg::REAL_W-1:0]     out_real_time_us,
  output logic [fit_pkg::NUM_LANES-1:0]  out_toggle
);

  localparam int TS_W      = fit_pkg::TS_W;
  localparam int NV_W      = fit_pkg::NV_W;
  localparam int CNT_W     = fit_pkg::CNT_W;
  localparam int PER_W     = fit_pkg::PER_W;
  localparam int WIN_W     = fit_pkg::WIN_W;
  localparam int LOOP_W    = fit_pkg::LOOP_W;
  localparam int REAL_W    = fit_pkg::REAL_W;
  localparam int DIVD_W    = fit_pkg::DIVD_W;
  localparam int NUM_LANES = fit_pkg::NUM_LANES;
  localparam int CMP_W     = (INTERVAL_BITS > PER_W) ? INTERVAL_BITS : PER_W;
  localparam int SUM_W     = CMP_W + 1;

  // Configuration.
  logic [PER_W-1:0]         max_frame_r;
  logic [WIN_W-1:0]         avg_window_r;
  logic [PER_W-1:0]         period_r [NUM_LANES];

  // Word in flight.
  logic [TS_W-1:0]          ts_r;
  logic [NV_W-1:0]          nv_r;

  // Timer state.
  logic [TS_W-1:0]          last_ts_r;
  logic [CNT_W-1:0]         frame_cnt_r;
  logic [TS_W-1:0]          elapsed_r;
  logic [INTERVAL_BITS-1:0] ivl_r;
  logic [TIME_BITS-1:0]     run_time_r;
  logic [PER_W-1:0]         phase_r  [NUM_LANES];
  logic [NUM_LANES-1:0]     level_r;

  // Toggle lanes between steps.
  logic [SUM_W-1:0]         sum_r    [NUM_LANES];
  logic [NUM_LANES-1:0]     wrap_r;

  // Result register.
  logic [LOOP_W-1:0]        out_loop_r;
  logic [REAL_W-1:0]        out_real_r;
  logic [NUM_LANES-1:0]     out_tog_r;

  logic [DIVD_W-1:0]        scaled;
  logic [DIVD_W-1:0]        quotient;
  logic                     div_done;
  logic [INTERVAL_BITS-1:0] quo_sat;
  logic [INTERVAL_BITS-1:0] nv_sat;
  logic [TS_W-1:0]          delta;

  assign delta   = ts_r - last_ts_r;
  assign scaled  = DIVD_W'(elapsed_r) * DIVD_W'(fit_pkg::SCALE);
  assign quo_sat = (|quotient[DIVD_W-1:INTERVAL_BITS]) ? '1 : quotient[INTERVAL_BITS-1:0];
  assign nv_sat  = (|nv_r[NV_W-1:INTERVAL_BITS]) ? '1 : nv_r[INTERVAL_BITS-1:0];

  fit_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (scaled),
    .divisor  (frame_cnt_r),
    .done     (div_done),
    .quotient (quotient)
  );

  assign status.over_window = elapsed_r > TS_W'(avg_window_r);
  assign status.div_done    = div_done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_frame_r  <= fit_pkg::MAX_FRAME_RST;
      avg_window_r <= fit_pkg::AVG_WINDOW_RST;
      period_r[0]  <= fit_pkg::PERIOD_A_RST;
      period_r[1]  <= fit_pkg::PERIOD_B_RST;
      period_r[2]  <= fit_pkg::PERIOD_C_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        fit_pkg::CFG_MAX_FRAME:  max_frame_r  <= cfg_wdata;
        fit_pkg::CFG_AVG_WINDOW: avg_window_r <= cfg_wdata[WIN_W-1:0];
        fit_pkg::CFG_PERIOD_A:   period_r[0]  <= cfg_wdata;
        fit_pkg::CFG_PERIOD_B:   period_r[1]  <= cfg_wdata;
        fit_pkg::CFG_PERIOD_C:   period_r[2]  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ts_r <= in_timestamp_ms;
      nv_r <= in_new_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_ts_r   <= '0;
      frame_cnt_r <= '0;
      elapsed_r   <= '0;
      ivl_r       <= '0;
      run_time_r  <= '0;
      level_r     <= '1;
      for (int i = 0; i < NUM_LANES; i++) begin
        phase_r[i] <= '0;
      end
    end else begin
      if (cmd.tick_upd) begin
        last_ts_r <= ts_r;
        elapsed_r <= elapsed_r + delta;
        if (frame_cnt_r != '1) begin
          frame_cnt_r <= frame_cnt_r + CNT_W'(1);
        end
      end
      if (cmd.load_time) begin
        run_time_r <= TIME_BITS'(nv_r);
      end
      if (cmd.load_ivl) begin
        ivl_r <= nv_sat;
      end
      if (cmd.div_take) begin
        ivl_r       <= quo_sat;
        frame_cnt_r <= '0;
        elapsed_r   <= '0;
      end
      if (cmd.clamp && (CMP_W'(ivl_r) > CMP_W'(max_frame_r))) begin
        ivl_r <= INTERVAL_BITS'(max_frame_r);
      end
      if (cmd.accum) begin
        run_time_r <= run_time_r + TIME_BITS'(ivl_r);
      end
      for (int i = 0; i < NUM_LANES; i++) begin
        if (cmd.tog_sub && (sum_r[i] >= SUM_W'(period_r[i]))) begin
          level_r[i] <= ~level_r[i];
        end
        if (cmd.tog_fix) begin
          phase_r[i] <= (wrap_r[i] && (sum_r[i] >= SUM_W'(period_r[i]))) ?
                        '0 : sum_r[i][PER_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_LANES; i++) begin
      if (cmd.accum) begin
        sum_r[i] <= SUM_W'(phase_r[i]) + SUM_W'(ivl_r);
      end else if (cmd.tog_sub) begin
        wrap_r[i] <= sum_r[i] >= SUM_W'(period_r[i]);
        if (sum_r[i] >= SUM_W'(period_r[i])) begin
          sum_r[i] <= sum_r[i] - SUM_W'(period_r[i]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_loop_r <= LOOP_W'(ivl_r);
      out_real_r <= REAL_W'(run_time_r);
      out_tog_r  <= level_r;
    end
  end

  assign out_loop_time_us = out_loop_r;
  assign out_real_time_us = out_real_r;
  assign out_toggle       = out_tog_r;

endmodule

// ===== design/fit_ctrl.sv =====
`include "assert_macros.svh"

module fit_ctrl (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [fit_pkg::OP_W-1:0] in_op,
  output logic                     out_valid,
  input  logic                     out_ready,
  output fit_pkg::fit_cmd_t        cmd,
  input  fit_pkg::fit_status_t     status
);

  fit_pkg::fit_state_t       state_r;
  fit_pkg::fit_state_t       state_nxt;
  logic [fit_pkg::OP_W-1:0]  op_r;
  logic                      out_valid_r;
  logic                      out_valid_nxt;
  logic                      accept;

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fit_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r <= in_op;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      fit_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        if (in_valid) begin
          state_nxt = fit_pkg::ST_DECODE;
        end
      end
      fit_pkg::ST_DECODE: begin
        case (op_r)
          fit_pkg::OP_TICK: begin
            cmd.tick_upd = 1'b1;
            state_nxt    = fit_pkg::ST_CHECK;
          end
          fit_pkg::OP_LOAD_TIME: begin
            cmd.load_time = 1'b1;
            state_nxt     = fit_pkg::ST_DONE;
          end
          fit_pkg::OP_LOAD_IVL: begin
            cmd.load_ivl = 1'b1;
            state_nxt    = fit_pkg::ST_DONE;
          end
          default: state_nxt = fit_pkg::ST_DONE;
        endcase
      end
      fit_pkg::ST_CHECK: begin
        if (status.over_window) begin
          cmd.div_start = 1'b1;
          state_nxt     = fit_pkg::ST_DIV;
        end else begin
          state_nxt = fit_pkg::ST_CLAMP;
        end
      end
      fit_pkg::ST_DIV: begin
        if (status.div_done) begin
          cmd.div_take = 1'b1;
          state_nxt    = fit_pkg::ST_CLAMP;
        end
      end
      fit_pkg::ST_CLAMP: begin
        cmd.clamp = 1'b1;
        state_nxt = fit_pkg::ST_ACC;
      end
      fit_pkg::ST_ACC: begin
        cmd.accum = 1'b1;
        state_nxt = fit_pkg::ST_TOG_SUB;
      end
      fit_pkg::ST_TOG_SUB: begin
        cmd.tog_sub = 1'b1;
        state_nxt   = fit_pkg::ST_TOG_FIX;
      end
      fit_pkg::ST_TOG_FIX: begin
        cmd.tog_fix = 1'b1;
        state_nxt   = fit_pkg::ST_DONE;
      end
      fit_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = fit_pkg::ST_IDLE;
        end
      end
      default: state_nxt = fit_pkg::ST_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

  `FIT_ASSERT(a_accept_decode, accept |=> (state_r == fit_pkg::ST_DECODE), "accept did not start decode")
  `FIT_ASSERT(a_div_done_wait, status.div_done |-> (state_r == fit_pkg::ST_DIV), "divider done outside wait")
  `FIT_ASSERT(a_no_overwrite, cmd.out_load |-> (!out_valid_r || out_ready), "pending result overwritten")
  `FIT_ASSERT(a_check_div, (state_r == fit_pkg::ST_CHECK && status.over_window) |=> (state_r == fit_pkg::ST_DIV), "recompute skipped")
  `FIT_ASSERT_RST(a_reset_idle, !rst_n |=> (state_r == fit_pkg::ST_IDLE && !out_valid_r), "reset left block busy")

endmodule

// ===== design/frame_interval_timer.sv =====
// Path, accept to out_valid: a load goes through decode and done; a frame tick adds
// check, clamp, acc and both toggle steps; a recompute adds the 42-step divider.
// One word at a time: the next word is taken as soon as the previous one is parked
// in the result register.
// Reset (synchronous, rst_n low): registers to defaults, counters and time to zero,
// toggle levels to one, no result pending.
module frame_interval_timer #(
  parameter int TIME_BITS     = fit_pkg::TIME_BITS_DEF,
  parameter int INTERVAL_BITS = fit_pkg::INTERVAL_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // input words
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [fit_pkg::OP_W-1:0]       in_op,
  input  logic [fit_pkg::TS_W-1:0]       in_timestamp_ms,
  input  logic [fit_pkg::NV_W-1:0]       in_new_value,
  // result words
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [fit_pkg::LOOP_W-1:0]     out_loop_time_us,
  output logic [fit_pkg::REAL_W-1:0]     out_real_time_us,
  output logic                           out_toggle_a,
  output logic                           out_toggle_b,
  output logic                           out_toggle_c,
  // configuration writes
  input  logic                           cfg_wr_en,
  input  logic [fit_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fit_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  // The controller walks one word through the datapath step by step:
  //   decode  - apply a load, or fold the tick's timestamp delta into elapsed
  //             and bump the saturating frame count
  //   check   - if elapsed is past the window, launch elapsed*1000/count
  //   div     - wait out the serial divider, then take the saturated quotient
  //             and clear both counters
  //   clamp   - hold the interval at or under max_frame_us (every tick)
  //   acc     - advance the running time and form the three phase sums
  //   tog     - flip a level whose sum passed its period, subtract the period,
  //             then drop a sum that is still over to zero
  //   done    - park the state in the result register once it is free
  fit_pkg::fit_cmd_t                cmd;
  fit_pkg::fit_status_t             status;
  logic [fit_pkg::NUM_LANES-1:0]    toggles;

  fit_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_op     (in_op),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status)
  );

  fit_dpath #(
    .TIME_BITS     (TIME_BITS),
    .INTERVAL_BITS (INTERVAL_BITS)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .in_timestamp_ms  (in_timestamp_ms),
    .in_new_value     (in_new_value),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .out_loop_time_us (out_loop_time_us),
    .out_real_time_us (out_real_time_us),
    .out_toggle       (toggles)
  );

  // Lane order: a, b, c.
  assign out_toggle_a = toggles[0];
  assign out_toggle_b = toggles[1];
  assign out_toggle_c = toggles[2];

endmodule

// ===== sim/frame_interval_timer_tb.sv =====
module frame_interval_timer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fit_pkg::*;

  // Op code 3 has no meaning in the block; it must leave the state alone.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  localparam int CLK_HALF    = 4;
  localparam int MAX_BURST   = 18;
  localparam int TAIL_CYCLES = 64;
  localparam int PHASES      = 6;
  localparam int PHASE_WORDS = 313;
  localparam int MAX_PRINTED = 40;

  localparam logic [LOOP_W-1:0] IVL_SAT = '1;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic [TS_W-1:0] ts;
    logic [NV_W-1:0] nv;
  } timer_word_t;

  typedef struct packed {
    logic [LOOP_W-1:0]    loop_us;
    logic [REAL_W-1:0]    run_us;
    logic [NUM_LANES-1:0] level;   // bit 0 is toggle a
  } timer_result_t;

  // DUT signals; every input starts at a known value.
  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  in_valid    = 1'b0;
  logic                  in_ready;
  logic [OP_W-1:0]       in_op       = '0;
  logic [TS_W-1:0]       in_timestamp_ms = '0;
  logic [NV_W-1:0]       in_new_value    = '0;
  logic                  out_valid;
  logic                  out_ready   = 1'b0;
  logic [LOOP_W-1:0]     out_loop_time_us;
  logic [REAL_W-1:0]     out_real_time_us;
  logic                  out_toggle_a;
  logic                  out_toggle_b;
  logic                  out_toggle_c;
  logic                  cfg_wr_en   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata   = '0;

  // Predictor copy of the registers.
  logic [PER_W-1:0] max_frame_us;
  logic [WIN_W-1:0] avg_window_ms;
  logic [PER_W-1:0] half_period_us [NUM_LANES];

  // Predictor copy of the block state.
  logic [CNT_W-1:0]     prev_stamp;
  logic [CNT_W-1:0]     frames_seen;
  logic [CNT_W-1:0]     elapsed_ms;
  logic [LOOP_W-1:0]    interval_us;
  logic [REAL_W-1:0]    running_us;
  logic [PER_W-1:0]     phase_us [NUM_LANES];
  logic [NUM_LANES-1:0] level_q;

  timer_word_t   pending_words[$];
  timer_result_t expected_results[$];

  int   err_count = 0;
  int   send_gap  = 0;
  int   recv_gap  = 0;
  bit   idle_on   = 1'b1;
  timer_word_t   next_word;
  timer_result_t want;

  frame_interval_timer u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_timestamp_ms  (in_timestamp_ms),
    .in_new_value     (in_new_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_loop_time_us (out_loop_time_us),
    .out_real_time_us (out_real_time_us),
    .out_toggle_a     (out_toggle_a),
    .out_toggle_b     (out_toggle_b),
    .out_toggle_c     (out_toggle_c),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  always #(CLK_HALF) clk = ~clk;

  // Advance the predicted state by one accepted word and return the result word
  // it should produce. Every op yields exactly one result.
  function automatic timer_result_t predict_timer(timer_word_t w);
    logic [CNT_W-1:0] delta;
    logic [63:0]      quot;
    logic [PER_W:0]   sum;
    timer_result_t    r;
    case (w.op)
      OP_TICK: begin
        delta = w.ts - prev_stamp;
        // Saturate the frame count so the divisor never wraps back to zero.
        if (frames_seen != '1) frames_seen = frames_seen + 1'b1;
        elapsed_ms = elapsed_ms + delta;
        if (elapsed_ms > avg_window_ms) begin
          quot = (64'(elapsed_ms) * 64'd1000) / 64'(frames_seen);
          interval_us = (quot > 64'(IVL_SAT)) ? IVL_SAT : quot[LOOP_W-1:0];
          frames_seen = '0;
          elapsed_ms  = '0;
        end
        prev_stamp = w.ts;
        // Clamp on every tick, recomputed or not.
        if (interval_us > max_frame_us) interval_us = max_frame_us;
        running_us = running_us + interval_us;
        for (int i = 0; i < NUM_LANES; i++) begin
          sum = phase_us[i] + interval_us;
          if (sum >= half_period_us[i]) begin
            level_q[i] = ~level_q[i];
            sum = sum - half_period_us[i];
            // Drop whatever is still over a full period.
            if (sum >= half_period_us[i]) sum = '0;
          end
          phase_us[i] = sum[PER_W-1:0];
        end
      end
      OP_LOAD_TIME: running_us = w.nv[REAL_W-1:0];
      // Saturate to the interval range; the clamp waits for the next tick.
      OP_LOAD_IVL: interval_us = (w.nv[NV_W-1:LOOP_W] != '0) ? IVL_SAT : w.nv[LOOP_W-1:0];
      default: ;
    endcase
    r.loop_us = interval_us;
    r.run_us  = running_us;
    r.level   = level_q;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] exp_val);
    err_count++;
    if (err_count <= MAX_PRINTED)
      $display("%0t ns: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, exp_val);
  endtask

  task automatic queue_word(logic [OP_W-1:0] op, logic [TS_W-1:0] ts, logic [NV_W-1:0] nv);
    pending_words.push_back(timer_word_t'{op, ts, nv});
  endtask

  // Hold until nothing is queued, nothing is on the input port and every
  // expected result word has come back. Sample at the falling edge so the
  // values seen are settled.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_words.size() != 0 || in_valid || expected_results.size() != 0);
  endtask

  // Write all five registers, one per cycle, once the block is idle.
  task automatic write_setting(logic [PER_W-1:0] max_us, logic [WIN_W-1:0] win_ms,
                               logic [PER_W-1:0] pa, logic [PER_W-1:0] pb,
                               logic [PER_W-1:0] pc);
    wait_drained();
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_MAX_FRAME;
    cfg_wdata <= max_us;
    @(posedge clk);
    cfg_index <= CFG_AVG_WINDOW;
    cfg_wdata <= CFG_DATA_W'(win_ms);
    @(posedge clk);
    cfg_index <= CFG_PERIOD_A;
    cfg_wdata <= pa;
    @(posedge clk);
    cfg_index <= CFG_PERIOD_B;
    cfg_wdata <= pb;
    @(posedge clk);
    cfg_index <= CFG_PERIOD_C;
    cfg_wdata <= pc;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    max_frame_us      = max_us;
    avg_window_ms     = win_ms;
    half_period_us[0] = pa;
    half_period_us[1] = pb;
    half_period_us[2] = pc;
  endtask

  // Mostly a typical value, sometimes zero, one or all ones.
  function automatic logic [PER_W-1:0] pick_value(int unsigned lo, int unsigned hi);
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return PER_W'(1);
      2:       return '1;
      default: return PER_W'($urandom_range(lo, hi));
    endcase
  endfunction

  // Input driver: predict each word as it is taken, then offer the next one
  // from the pending queue, with random idle bursts between words.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready)
        expected_results.push_back(
          predict_timer(timer_word_t'{in_op, in_timestamp_ms, in_new_value}));
      // Hold valid and payload until the current word is accepted.
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_words.size() != 0) begin
          next_word = pending_words.pop_front();
          in_valid        <= 1'b1;
          in_op           <= next_word.op;
          in_timestamp_ms <= next_word.ts;
          in_new_value    <= next_word.nv;
          if (idle_on && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, MAX_BURST);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare each taken result word with the oldest
  // expectation, and stall the result port in random bursts.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result word with nothing expected", out_real_time_us, '0);
        end else begin
          want = expected_results.pop_front();
          if (out_loop_time_us !== want.loop_us)
            report_mismatch("loop_time_us", out_loop_time_us, want.loop_us);
          if (out_real_time_us !== want.run_us)
            report_mismatch("real_time_us", out_real_time_us, want.run_us);
          if (out_toggle_a !== want.level[0])
            report_mismatch("toggle_a", out_toggle_a, want.level[0]);
          if (out_toggle_b !== want.level[1])
            report_mismatch("toggle_b", out_toggle_b, want.level[1]);
          if (out_toggle_c !== want.level[2])
            report_mismatch("toggle_c", out_toggle_c, want.level[2]);
        end
      end
      if (recv_gap > 0) begin
        recv_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (idle_on && $urandom_range(0, 9) == 0) recv_gap = $urandom_range(1, MAX_BURST);
      end
    end
  end

  initial begin
    logic [TS_W-1:0] gen_stamp;
    logic [TS_W-1:0] junk_ts;
    logic [NV_W-1:0] junk_nv;
    int unsigned     roll;

    // Predicted state after reset.
    max_frame_us      = MAX_FRAME_RST;
    avg_window_ms     = AVG_WINDOW_RST;
    half_period_us[0] = PERIOD_A_RST;
    half_period_us[1] = PERIOD_B_RST;
    half_period_us[2] = PERIOD_C_RST;
    prev_stamp  = '0;
    frames_seen = '0;
    elapsed_ms  = '0;
    interval_us = '0;
    running_us  = '0;
    level_q     = '1;
    for (int i = 0; i < NUM_LANES; i++) phase_us[i] = '0;
    gen_stamp = '0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed words under the reset register values.
    queue_word(OP_UNUSED, '1, '1);                   // unused op shows the reset state
    queue_word(OP_TICK, 32'd5, '0);                  // inside the window
    queue_word(OP_TICK, 32'd11, '0);                 // crosses the window, recompute
    queue_word(OP_LOAD_IVL, '0, '1);                 // interval saturates, not yet clamped
    queue_word(OP_TICK, 32'd11, '0);                 // zero delta, clamp without recompute
    queue_word(OP_LOAD_TIME, '0, '1);                // running time all ones
    queue_word(OP_TICK, 32'd12, '0);                 // running time wraps
    queue_word(OP_TICK, '1, '0);                     // huge quotient saturates, then clamps
    queue_word(OP_TICK, 32'd3, '0);                  // timestamp wraps past zero
    queue_word(OP_TICK, 32'd30, '0);
    queue_word(OP_LOAD_IVL, '0, NV_W'(IVL_SAT));     // exactly the top of the range
    queue_word(OP_LOAD_IVL, '0, NV_W'(25'h1000000)); // one above the range
    queue_word(OP_LOAD_TIME, '0, '0);
    queue_word(OP_TICK, 32'h8000_0000, NV_W'({$urandom(), $urandom()}));

    // Zero clamp and zero periods: interval goes to zero, toggles flip each tick.
    write_setting('0, '0, '0, '0, '0);
    queue_word(OP_TICK, 32'h8000_0001, '0);
    queue_word(OP_TICK, 32'h8000_0009, '0);
    queue_word(OP_TICK, 32'h8000_0040, '0);

    // Widest clamp and window, smallest and largest periods.
    write_setting('1, '1, PER_W'(1), '1, PER_W'(24'h800000));
    queue_word(OP_LOAD_IVL, '0, NV_W'(IVL_SAT));
    queue_word(OP_TICK, 32'h8000_0041, '0);
    queue_word(OP_TICK, 32'h8000_0042, '0);

    // Build up the phase sums, then shrink the periods below them.
    write_setting('1, '1, PER_W'(24'hF00000), PER_W'(24'hF00000), PER_W'(24'hF00000));
    queue_word(OP_LOAD_IVL, '0, NV_W'(24'h900000));
    queue_word(OP_TICK, 32'h8000_0043, '0);
    write_setting('1, '1, PER_W'(24'h100000), PER_W'(24'h100000), PER_W'(24'h100000));
    queue_word(OP_TICK, 32'h8000_0044, '0);

    // Random phases, each under its own register setting. Most words are
    // ticks with a steadily advancing clock so the averaging actually runs;
    // the rest are loads, clock jumps and the unused op.
    gen_stamp = 32'h8000_0044;
    for (int p = 0; p < PHASES; p++) begin
      if (p == 0)
        write_setting(MAX_FRAME_RST, AVG_WINDOW_RST, PERIOD_A_RST, PERIOD_B_RST,
                      PERIOD_C_RST);
      else
        write_setting(pick_value(5000, 2000000), WIN_W'(pick_value(0, 60)),
                      pick_value(1000, 150000), pick_value(1000, 150000),
                      pick_value(1000, 150000));
      // The last phase runs both ports flat out.
      if (p == PHASES - 1) idle_on = 1'b0;
      for (int k = 0; k < PHASE_WORDS; k++) begin
        // Hold the sender mid-phase until every result word has come back.
        if (p == 2 && k == PHASE_WORDS / 2) wait_drained();
        roll    = $urandom_range(0, 99);
        junk_ts = $urandom();
        junk_nv = NV_W'({$urandom(), $urandom()});
        if (roll < 78) begin
          if ($urandom_range(0, 29) == 0) gen_stamp = gen_stamp + $urandom_range(0, 5000);
          else                            gen_stamp = gen_stamp + $urandom_range(0, 40);
          queue_word(OP_TICK, gen_stamp, junk_nv);
        end else if (roll < 84) begin
          gen_stamp = junk_ts;
          queue_word(OP_TICK, junk_ts, junk_nv);
        end else if (roll < 90) begin
          queue_word(OP_LOAD_TIME, junk_ts,
                     roll[0] ? junk_nv : NV_W'($urandom_range(0, 1000000)));
        end else if (roll < 97) begin
          queue_word(OP_LOAD_IVL, junk_ts,
                     ($urandom_range(0, 3) == 0) ? junk_nv : NV_W'($urandom_range(0, 300000)));
        end else begin
          queue_word(OP_UNUSED, junk_ts, junk_nv);
        end
      end
    end

    wait_drained();
    // Let any stray result word show up before judging.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0)
      $display("** frame_interval_timer: PASSED **");
    else
      $display("** frame_interval_timer: FAILED **");
    $finish;
  end

  // Watchdog: a correct run needs well under a quarter of this.
  initial begin
    #(8_000_000);
    $display("** frame_interval_timer: FAILED **");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/fit_pkg.sv
design/fit_div.sv
design/fit_dpath.sv
design/fit_ctrl.sv
design/frame_interval_timer.sv
sim/frame_interval_timer_tb.sv
